/* rtl/core/itra_pkg.sv */
// shared types and constants for the integer to radix ascii converter
`default_nettype none
package itra_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned RADIX_W  = 6;
  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned STACK_DEPTH = 34;
  localparam int unsigned COUNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned STEP_W   = $clog2(VALUE_W);

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] BASE_DEC    = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX    = 6'd16;
  localparam logic [RADIX_W-1:0] BASE_OCT    = 6'd8;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_X     = 7'h78;

  typedef enum logic [1:0] {
    PUSH_DIGIT = 2'd0,
    PUSH_MINUS = 2'd1,
    PUSH_X     = 2'd2,
    PUSH_ZERO  = 2'd3
  } push_sel_t;

  typedef struct packed {
    logic      load;
    logic      div_step;
    logic      push;
    push_sel_t push_sel;
    logic      rem_clear;
    logic      pop;
  } cmd_t;

  typedef struct packed {
    logic quot_zero;
    logic negative;
    logic base_dec;
    logic base_hex;
    logic base_oct;
    logic count_one;
  } status_t;

endpackage
`default_nettype wire

/* rtl/core/itra_dp.sv */
// datapath: radix register, restoring divider and character stack
`default_nettype none
module itra_dp (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cfg_we,
  input  wire [itra_pkg::RADIX_W-1:0] cfg_data,
  input  wire [itra_pkg::VALUE_W-1:0] value,
  input  itra_pkg::cmd_t              cmd,
  output itra_pkg::status_t           status,
  output logic [itra_pkg::CHAR_W-1:0] character
);
  import itra_pkg::*;

  logic [RADIX_W-1:0] radix;
  logic [RADIX_W-1:0] base;
  logic [VALUE_W-1:0] num;
  logic [RADIX_W-1:0] rem;
  logic               negative;
  logic [RADIX_W:0]   trial;
  logic               fits;
  logic [CHAR_W-1:0]  digit_char;
  logic [CHAR_W-1:0]  push_char;
  logic [CHAR_W-1:0]  stack [STACK_DEPTH];
  logic [COUNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_we) begin
      radix <= cfg_data;
    end
  end

  always_comb begin
    if (radix < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix;
    end
  end

  // one quotient bit per step, remainder stays below the base
  assign trial = {rem, num[VALUE_W-1]};
  assign fits  = trial >= {1'b0, base};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      negative <= value[VALUE_W-1];
      rem      <= '0;
      if (base == BASE_DEC && value[VALUE_W-1]) begin
        num <= '0 - value;
      end else begin
        num <= value;
      end
    end else if (cmd.div_step) begin
      if (fits) begin
        rem <= RADIX_W'(trial - {1'b0, base});
      end else begin
        rem <= trial[RADIX_W-1:0];
      end
      num <= {num[VALUE_W-2:0], fits};
    end else if (cmd.rem_clear) begin
      rem <= '0;
    end
  end

  always_comb begin
    if (rem < 6'd10) begin
      digit_char = CHAR_ZERO + CHAR_W'(rem);
    end else begin
      digit_char = CHAR_UPPER + CHAR_W'(rem - 6'd10);
    end
  end

  always_comb begin
    case (cmd.push_sel)
      PUSH_DIGIT: push_char = digit_char;
      PUSH_MINUS: push_char = CHAR_MINUS;
      PUSH_X:     push_char = CHAR_X;
      PUSH_ZERO:  push_char = CHAR_ZERO;
      default:    push_char = digit_char;
    endcase
  end

  // last pushed character sits on top, so text comes out most significant first
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack[0] <= push_char;
      for (int i = 1; i < STACK_DEPTH; i++) begin
        stack[i] <= stack[i-1];
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < STACK_DEPTH - 1; i++) begin
        stack[i] <= stack[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load) begin
      count <= '0;
    end else if (cmd.push) begin
      count <= count + 1'b1;
    end else if (cmd.pop) begin
      count <= count - 1'b1;
    end
  end

  assign character        = stack[0];
  assign status.quot_zero = num == '0;
  assign status.negative  = negative;
  assign status.base_dec  = base == BASE_DEC;
  assign status.base_hex  = base == BASE_HEX;
  assign status.base_oct  = base == BASE_OCT;
  assign status.count_one = count == COUNT_W'(1);

endmodule
`default_nettype wire

/* rtl/core/itra_ctrl.sv */
// controller: sequences division steps, prefix pushes and character output
`default_nettype none
module itra_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  wire               out_stall,
  input  itra_pkg::status_t status,
  output itra_pkg::cmd_t    cmd
);
  import itra_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_PUSH = 6'b000100,
    S_PFX1 = 6'b001000,
    S_PFX2 = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;

  assign in_stall  = state != S_IDLE;
  assign out_valid = state == S_EMIT;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.push_sel  = PUSH_DIGIT;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step == '1) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push      = 1'b1;
        cmd.rem_clear = 1'b1;
        state_next    = status.quot_zero ? S_PFX1 : S_DIV;
      end
      S_PFX1: begin
        // hex needs two prefix characters, pushed in reverse
        if (status.base_hex) begin
          cmd.push     = 1'b1;
          cmd.push_sel = PUSH_X;
        end
        state_next = S_PFX2;
      end
      S_PFX2: begin
        if (status.base_hex || status.base_oct) begin
          cmd.push     = 1'b1;
          cmd.push_sel = PUSH_ZERO;
        end else if (status.base_dec && status.negative) begin
          cmd.push     = 1'b1;
          cmd.push_sel = PUSH_MINUS;
        end
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_stall) begin
          cmd.pop = 1'b1;
          if (status.count_one) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        step <= step + 1'b1;
      end else begin
        step <= '0;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/integer_to_radix_ascii.sv */
// top level: integer to ascii text in a configurable base, signed in base 10 only
//
//   channel  | signals                       | direction
//   ---------+-------------------------------+----------
//   input    | in_valid, in_stall, value     | in
//   output   | out_valid, out_stall,         | out
//            |   character, last             |
//   config   | cfg_we, cfg_data              | in
//
// each digit takes 32 restoring division steps by the base plus one push onto
// the character stack; then the prefix states run and the stack is popped, one
// character per beat. rst is synchronous and sets the radix to 10. a new value
// is taken only once the last beat has gone out; out_stall holds the current
// character in place.
`default_nettype none
module integer_to_radix_ascii (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cfg_we,
  input  wire [itra_pkg::RADIX_W-1:0] cfg_data,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire [itra_pkg::VALUE_W-1:0] value,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic [itra_pkg::CHAR_W-1:0] character,
  output logic                        last
);
  import itra_pkg::*;

  cmd_t    cmd;
  status_t status;

  itra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  itra_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .value     (value),
    .cmd       (cmd),
    .status    (status),
    .character (character)
  );

  assign last = status.count_one;

endmodule
`default_nettype wire

/* test/itra_checker.sv */
// checker for integer_to_radix_ascii: predicts each value's text and compares every beat
`default_nettype none
module itra_checker (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire [itra_pkg::RADIX_W-1:0]  cfg_data,
  input  wire                          in_valid,
  input  wire                          in_stall,
  input  wire [itra_pkg::VALUE_W-1:0]  value,
  input  wire                          out_valid,
  input  wire                          out_stall,
  input  wire [itra_pkg::CHAR_W-1:0]   character,
  input  wire                          last,
  output wire [31:0]                   mismatches,
  output logic [31:0]                  chars_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import itra_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_beat_t;

  text_beat_t       expected_text[$];
  text_beat_t       want;
  logic [RADIX_W-1:0] radix_copy = RADIX_RESET;
  int unsigned      fail_count = 0;

  initial chars_due = 0;
  assign mismatches = fail_count;

  task automatic report_mismatch(input string msg);
    if (fail_count < 200) $display("mismatch at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // builds the text of one value in the current base and queues its beats
  function automatic void queue_text(input logic [VALUE_W-1:0] pattern);
    logic [RADIX_W-1:0] base;
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] digit;
    logic [CHAR_W-1:0]  reversed[$];
    text_beat_t         beat;
    base = radix_copy;
    if (base < RADIX_MIN) base = RADIX_MIN;
    else if (base > RADIX_MAX) base = RADIX_MAX;
    // only base 10 shows a sign, other bases show the raw pattern
    mag = (base == BASE_DEC && pattern[VALUE_W-1]) ? 32'd0 - pattern : pattern;
    do begin
      digit = mag % {26'd0, base};
      if (digit < 10) reversed.push_back(CHAR_ZERO + CHAR_W'(digit));
      else reversed.push_back(CHAR_UPPER + CHAR_W'(digit) - 7'd10);
      mag = mag / {26'd0, base};
    end while (mag != 0);
    if (base == BASE_DEC) begin
      if (pattern[VALUE_W-1]) reversed.push_back(CHAR_MINUS);
    end else if (base == BASE_HEX) begin
      reversed.push_back(CHAR_X);
      reversed.push_back(CHAR_ZERO);
    end else if (base == BASE_OCT) begin
      reversed.push_back(CHAR_ZERO);
    end
    for (int i = reversed.size() - 1; i >= 0; i--) begin
      beat.code = reversed[i];
      beat.last = (i == 0);
      expected_text.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      radix_copy = RADIX_RESET;
      expected_text.delete();
    end else begin
      // outputs first so a beat cannot match text queued at this same edge
      if (out_valid && !out_stall) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("unexpected beat char %h last %b", character, last));
        end else begin
          want = expected_text.pop_front();
          if (character !== want.code)
            report_mismatch($sformatf("char %h, expected %h", character, want.code));
          if (last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", last, want.last));
        end
      end
      if (cfg_we) radix_copy = cfg_data;
      if (in_valid && !in_stall) queue_text(value);
    end
    chars_due <= expected_text.size();
  end

endmodule
`default_nettype wire

/* test/tb_integer_to_radix_ascii.sv */
// testbench top for integer_to_radix_ascii: stimulus, stalls and verdict
`default_nettype none
module tb_integer_to_radix_ascii;
  timeunit 1ns;
  timeprecision 1ps;
  import itra_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [RADIX_W-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [VALUE_W-1:0] value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CHAR_W-1:0]  character;
  logic               last;
  logic [31:0]        mismatches;
  logic [31:0]        chars_due;
  logic               hold_req = 1'b0;
  logic               quiet = 1'b0;

  always #4 clk = ~clk;

  integer_to_radix_ascii u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last)
  );

  itra_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .character  (character),
    .last       (last),
    .mismatches (mismatches),
    .chars_due  (chars_due)
  );

  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 6))
      0: return VALUE_W'($urandom_range(0, 40));
      1: return 32'd0 - VALUE_W'($urandom_range(1, 40));
      2: return {1'b1, 31'($urandom)};
      3: return {1'b0, 31'($urandom)};
      4: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_value(input logic [VALUE_W-1:0] v);
    while (!quiet && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      value    <= $urandom;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering and wait until every queued character has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (chars_due != 0);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    cfg_we   <= 1'b1;
    cfg_data <= r;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cfg_data <= RADIX_W'($urandom);
  endtask

  // receiver: random stalls, one long hold-off, none while quiet
  initial begin
    logic held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
      out_stall <= !quiet && ($urandom_range(0, 99) < 31);
    end
  end

  initial begin
    logic [RADIX_W-1:0] r;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // base 10 straight out of reset, signs and extremes
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hffff_ffff);
    send_value(32'h7fff_ffff);
    send_value(32'h8000_0000);
    send_value(32'd10);
    drain();
    write_radix(BASE_HEX);
    send_value(32'd0);
    send_value(32'hffff_ffff);
    send_value(32'h8000_0000);
    drain();
    write_radix(BASE_OCT);
    send_value(32'd0);
    send_value(32'd7);
    drain();
    write_radix(RADIX_MIN);
    send_value(32'hffff_ffff);
    send_value(32'd0);
    drain();
    write_radix(RADIX_MAX);
    send_value(32'd35);
    send_value(32'd36);
    send_value(32'hffff_ffff);
    drain();
    // out-of-range radix settings clamp to 2 and 36
    write_radix(6'd0);
    send_value(32'd5);
    drain();
    write_radix(6'd1);
    send_value(32'd2);
    drain();
    write_radix(6'd63);
    send_value(32'hffff_ffff);
    drain();
    write_radix(6'd37);
    send_value(32'd100);
    drain();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: r = RADIX_MIN;
        1: r = RADIX_MAX;
        2: r = BASE_DEC;
        3: r = BASE_HEX;
        4: r = BASE_OCT;
        default: r = RADIX_W'($urandom_range(0, 63));
      endcase
      write_radix(r);
      if (p == 2) hold_req <= 1'b1;
      quiet <= (p == 6);
      repeat (11) send_value(random_value());
      drain();
    end

    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout at %0t ns, %0d characters still due", $time, chars_due);
    $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire
